/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define AMAO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define AMAO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/amao_pkg.sv */
package amao_pkg;

  // Width of one axis sample and of one average.
  localparam int unsigned AXIS_W = 6;

  // Bit positions inside the raw axis byte and the tilt byte.
  localparam int unsigned FAIL_BIT  = 6;
  localparam int unsigned TAP_BIT   = 5;
  localparam int unsigned SHAKE_BIT = 7;

  // Orientation codes reported in a result.
  typedef enum logic [2:0] {
    ORIENT_UNKNOWN = 3'd0,
    ORIENT_LEFT    = 3'd1,
    ORIENT_RIGHT   = 3'd2,
    ORIENT_DOWN    = 3'd3,
    ORIENT_UP      = 3'd4
  } orient_t;

  // Orientation field of the tilt byte (bits 4:2).
  localparam logic [2:0] TILT_LEFT  = 3'd1;
  localparam logic [2:0] TILT_RIGHT = 3'd2;
  localparam logic [2:0] TILT_DOWN  = 3'd5;
  localparam logic [2:0] TILT_UP    = 3'd6;

  // Per-cycle enables that the top level hands to every axis lane.
  typedef struct packed {
    logic upd;   // a request was accepted: shift the ring, update the sum
    logic ld1;   // load the sign and magnitude stage
    logic ld2;   // load the reciprocal product stage
  } lane_ctl_t;

  // Map the tilt byte to the reported orientation code.
  function automatic orient_t orient_decode(input logic [7:0] tilt);
    orient_t code;
    case (tilt[4:2])
      TILT_LEFT:  code = ORIENT_LEFT;
      TILT_RIGHT: code = ORIENT_RIGHT;
      TILT_DOWN:  code = ORIENT_DOWN;
      TILT_UP:    code = ORIENT_UP;
      default:    code = ORIENT_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

/* rtl/core/accel_moving_average_orientation.sv */
// Three-axis boxcar moving average with orientation report. Each request on
// the input stream carries one accelerometer sample (three axis bytes and a
// tilt byte); the block takes one request per clock cycle and stalls only
// while its output register is full and not taken. Three axis lanes work
// side by side, each keeping its WINDOW_LEN-deep ring as a circular shift
// line with a running sum, and each dividing by WINDOW_LEN through a
// reciprocal multiply. A result is produced when the ring index wraps or
// when the tilt byte differs from a nonzero previously reported tilt; it
// moves through the magnitude and product stages into the output register.
// Samples that cause no result update the window and produce nothing.
// The rings and sums are cleared directly by reset; no clearing pass.
module accel_moving_average_orientation
  import amao_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // Sample stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] x_raw, [15:8] y_raw, [23:16] z_raw, [31:24] tilt_status
  input  logic [31:0] in_tdata,
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] avg_x, [11:6] avg_y, [17:12] avg_z, [20:18] orientation,
  // [21] tap_seen, [22] shake_seen, [23] zero
  output logic [23:0] out_tdata
);

  localparam int unsigned IDX_W = $clog2(WINDOW_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_LEN - 1);

  logic [IDX_W-1:0]        idx_r;
  logic [7:0]              last_tilt_r;
  logic [7:0]              tilt;
  logic                    accept;
  logic                    report;
  logic                    v1_r;
  logic                    v2_r;
  logic                    out_valid_r;
  logic [7:0]              tilt1_r;
  logic [7:0]              tilt2_r;
  logic [23:0]             out_data_r;
  logic                    out_rdy;
  logic                    s2_rdy;
  logic                    s1_rdy;
  logic                    ld3;
  lane_ctl_t               ctl;
  logic signed [AXIS_W-1:0] avg_x;
  logic signed [AXIS_W-1:0] avg_y;
  logic signed [AXIS_W-1:0] avg_z;
  orient_t                 orient;

  // Pipeline flow control: each stage loads when empty or when it drains.
  assign out_rdy   = !out_valid_r || out_tready;
  assign s2_rdy    = !v2_r || out_rdy;
  assign s1_rdy    = !v1_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign accept    = in_tvalid && in_tready;
  assign ld3       = v2_r && out_rdy;

  assign tilt = in_tdata[31:24];

  // Report on index wrap or on a change from a nonzero reported tilt.
  assign report = (idx_r == IDX_LAST) ||
                  ((last_tilt_r != 8'd0) && (last_tilt_r != tilt));

  assign ctl.upd = accept;
  assign ctl.ld1 = accept && report;
  assign ctl.ld2 = v1_r && s2_rdy;

  // Ring index and last reported tilt.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      last_tilt_r <= '0;
    end else if (accept) begin
      idx_r <= (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
      if (report) begin
        last_tilt_r <= tilt;
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        v1_r <= ctl.ld1;
      end
      if (s2_rdy) begin
        v2_r <= v1_r;
      end
      if (out_rdy) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // Tilt byte travels alongside the lane stages.
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      tilt1_r <= tilt;
    end
    if (ctl.ld2) begin
      tilt2_r <= tilt1_r;
    end
  end

  // One lane per axis.
  amao_lane #(.WINDOW_LEN(WINDOW_LEN)) u_lane_x (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .raw   (in_tdata[7:0]),
    .avg   (avg_x)
  );

  amao_lane #(.WINDOW_LEN(WINDOW_LEN)) u_lane_y (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .raw   (in_tdata[15:8]),
    .avg   (avg_y)
  );

  amao_lane #(.WINDOW_LEN(WINDOW_LEN)) u_lane_z (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .raw   (in_tdata[23:16]),
    .avg   (avg_z)
  );

  assign orient = orient_decode(tilt2_r);

  // Merge the lane averages and the tilt fields into the output register.
  always_ff @(posedge clk) begin
    if (ld3) begin
      out_data_r <= {1'b0, tilt2_r[SHAKE_BIT], tilt2_r[TAP_BIT], orient,
                     avg_z, avg_y, avg_x};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/core/amao_lane.sv */
module amao_lane
  import amao_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lane_ctl_t                ctl,
  input  logic [7:0]               raw,
  output logic signed [AXIS_W-1:0] avg
);

  // Sum spans -32 to 31 times WINDOW_LEN; the divider takes its magnitude.
  localparam int unsigned MAG_W  = $clog2(32 * WINDOW_LEN + 1);
  localparam int unsigned SUM_W  = MAG_W + 1;
  localparam int unsigned DIV_SH = MAG_W + $clog2(WINDOW_LEN);
  localparam int unsigned PROD_W = MAG_W + DIV_SH;
  // Rounded-up reciprocal; exact for every magnitude below 2**MAG_W.
  localparam logic [DIV_SH-1:0] DIV_MUL =
    DIV_SH'((2 ** DIV_SH + WINDOW_LEN - 1) / WINDOW_LEN);

  logic signed [AXIS_W-1:0] ring_r [WINDOW_LEN];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [AXIS_W-1:0] tail;
  logic signed [AXIS_W-1:0] sample;
  logic                     fail;
  logic [MAG_W-1:0]         mag_nxt;
  logic [MAG_W-1:0]         mag_r;
  logic                     neg1_r;
  logic [PROD_W-1:0]        prod_r;
  logic                     neg2_r;
  logic [AXIS_W-1:0]        quot;

  // The ring is a circular shift line: the tail is the slot being replaced.
  assign tail   = ring_r[WINDOW_LEN-1];
  assign fail   = raw[FAIL_BIT];
  assign sample = signed'(raw[AXIS_W-1:0]);

  // A failed sample is dropped: the tail re-enters, the sum is left alone.
  always_comb begin
    if (fail) begin
      sum_nxt = sum_r;
    end else begin
      sum_nxt = sum_r - {{(SUM_W-AXIS_W){tail[AXIS_W-1]}}, tail}
                      + {{(SUM_W-AXIS_W){sample[AXIS_W-1]}}, sample};
    end
  end

  // Ring and running sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ring_r[i] <= '0;
      end
      sum_r <= '0;
    end else if (ctl.upd) begin
      ring_r[0] <= fail ? tail : sample;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        ring_r[i] <= ring_r[i-1];
      end
      sum_r <= sum_nxt;
    end
  end

  // Sign and magnitude of the updated sum.
  assign mag_nxt = sum_nxt[SUM_W-1] ? MAG_W'(-sum_nxt) : MAG_W'(sum_nxt);

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      mag_r  <= mag_nxt;
      neg1_r <= sum_nxt[SUM_W-1];
    end
  end

  // Multiply by the reciprocal of the window length.
  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(DIV_MUL);
      neg2_r <= neg1_r;
    end
  end

  // Quotient magnitude is at most 32, so six bits hold the signed result.
  assign quot = prod_r[DIV_SH +: AXIS_W];
  assign avg  = neg2_r ? signed'(-quot) : signed'(quot);

endmodule

/* rtl/core/amao_checker.sv */
`include "assert_macros.svh"

module amao_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // The output register is empty right after reset.
  `AMAO_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

  // A stalled result keeps its data.
  `AMAO_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // The input only stalls behind a full, untaken output register.
  `AMAO_ASSERT(a_stall_cause, !in_tready |-> out_tvalid && !out_tready, "input stalled without output back-pressure")

  // Orientation code stays within its defined values.
  `AMAO_ASSERT(a_orient_range, out_tvalid |-> out_tdata[20:18] <= 3'd4, "orientation code out of range")

  // Padding bit of the result is always zero.
  `AMAO_ASSERT(a_pad_zero, out_tvalid |-> !out_tdata[23], "result padding bit set")

endmodule

bind accel_moving_average_orientation amao_checker u_amao_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
  import amao_pkg::*;

  localparam int WIN_LEN = 20;
  localparam int HOLD_CYCLES = 300;

  // One sample as it travels on in_tdata, x_raw in the lowest byte.
  typedef struct packed {
    logic [7:0] tilt;
    logic [7:0] z_raw;
    logic [7:0] y_raw;
    logic [7:0] x_raw;
  } accel_word_t;

  // One report as it travels on out_tdata, avg_x in the lowest bits.
  typedef struct packed {
    logic              pad;
    logic              shake_seen;
    logic              tap_seen;
    orient_t           orientation;
    logic signed [5:0] avg_z;
    logic signed [5:0] avg_y;
    logic signed [5:0] avg_x;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  accel_moving_average_orientation #(
    .WINDOW_LEN(WIN_LEN)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  // Samples waiting to be offered and reports the window model predicts.
  accel_word_t pending_samples[$];
  result_t expected_reports[$];

  // Traffic knobs, changed only between clock edges.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_arm = 1'b0;
  bit          hold_used = 1'b0;
  int unsigned hold_left = 0;

  // Run statistics.
  int unsigned samples_taken = 0;
  int unsigned reports_seen = 0;
  int unsigned blocked_cycles = 0;
  int unsigned failed_axes = 0;
  int unsigned mismatches = 0;

  // Window model state.
  logic signed [5:0] win_ring [3][WIN_LEN] = '{default: '0};
  int                win_sum [3] = '{default: 0};
  int unsigned       win_pos = 0;
  logic [7:0]        reported_tilt = '0;

  // Apply one accepted sample to the window model and queue the report it causes.
  task automatic advance_window(input accel_word_t s);
    logic [7:0]        raw [3];
    logic signed [5:0] v;
    result_t           r;
    raw[0] = s.x_raw;
    raw[1] = s.y_raw;
    raw[2] = s.z_raw;
    for (int a = 0; a < 3; a++) begin
      if (!raw[a][FAIL_BIT]) begin
        v = raw[a][5:0];
        win_sum[a] = win_sum[a] - int'(win_ring[a][win_pos]) + int'(v);
        win_ring[a][win_pos] = v;
      end else begin
        failed_axes++;
      end
    end
    win_pos = (win_pos == WIN_LEN - 1) ? 0 : win_pos + 1;
    if (win_pos == 0 || (reported_tilt != 8'd0 && reported_tilt != s.tilt)) begin
      r.pad = 1'b0;
      r.avg_x = 6'(win_sum[0] / WIN_LEN);
      r.avg_y = 6'(win_sum[1] / WIN_LEN);
      r.avg_z = 6'(win_sum[2] / WIN_LEN);
      case (s.tilt[4:2])
        TILT_LEFT:  r.orientation = ORIENT_LEFT;
        TILT_RIGHT: r.orientation = ORIENT_RIGHT;
        TILT_DOWN:  r.orientation = ORIENT_DOWN;
        TILT_UP:    r.orientation = ORIENT_UP;
        default:    r.orientation = ORIENT_UNKNOWN;
      endcase
      r.tap_seen = s.tilt[TAP_BIT];
      r.shake_seen = s.tilt[SHAKE_BIT];
      expected_reports.push_back(r);
      reported_tilt = s.tilt;
    end
  endtask

  function automatic string fmt_report(input result_t r);
    return $sformatf("x=%0d y=%0d z=%0d orient=%0d tap=%0b shake=%0b pad=%0b",
                     r.avg_x, r.avg_y, r.avg_z, r.orientation, r.tap_seen,
                     r.shake_seen, r.pad);
  endfunction

  // Compare one received report against the oldest prediction.
  task automatic check_report(input result_t got);
    result_t want;
    if (expected_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Result check failed: report with none predicted, got %s",
                 fmt_report(got));
      return;
    end
    want = expected_reports.pop_front();
    if (got.avg_x !== want.avg_x || got.avg_y !== want.avg_y ||
        got.avg_z !== want.avg_z || got.orientation !== want.orientation ||
        got.tap_seen !== want.tap_seen || got.shake_seen !== want.shake_seen ||
        got.pad !== want.pad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Result check failed at %0t: expected %s, got %s", $time,
                 fmt_report(want), fmt_report(got));
    end
  endtask

  // Sample driver: feeds the pending queue onto the input stream.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        samples_taken++;
        advance_window(accel_word_t'(in_tdata));
      end
      if (in_tvalid && !in_tready) blocked_cycles++;
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata <= pending_samples.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here once it is armed.
  always @(posedge clk) begin
    if (hold_arm && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Report monitor with random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        reports_seen++;
        check_report(result_t'(out_tdata));
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Axis byte: random value, failure flag set about one time in five.
  function automatic logic [7:0] rand_axis();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    b[FAIL_BIT] = ($urandom_range(4) == 0);
    return b;
  endfunction

  // Queue a phase of random samples, then wait until all of it is reported.
  task automatic run_phase(input int unsigned count, input int unsigned idle_pct,
                           input int unsigned stall_pct, input bit with_hold);
    logic [7:0]  tilt;
    logic [7:0]  run_byte [3];
    int unsigned run_left;
    accel_word_t s;
    tilt = 8'($urandom_range(255));
    run_left = 0;
    @(negedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (with_hold) hold_arm = 1'b1;
    for (int unsigned i = 0; i < count; i++) begin
      // Now and then a full window of one value can push the averages to their ends.
      if (run_left == 0 && $urandom_range(99) < 4) begin
        run_left = WIN_LEN;
        for (int a = 0; a < 3; a++) begin
          case ($urandom_range(3))
            0: run_byte[a] = 8'h1F;
            1: run_byte[a] = 8'h20;
            2: run_byte[a] = 8'hBF;
            default: run_byte[a] = 8'($urandom_range(255)) & 8'hBF;
          endcase
        end
      end
      if (run_left != 0) begin
        run_left--;
        s.x_raw = run_byte[0];
        s.y_raw = run_byte[1];
        s.z_raw = run_byte[2];
      end else begin
        s.x_raw = rand_axis();
        s.y_raw = rand_axis();
        s.z_raw = rand_axis();
      end
      // Tilt mostly steady, sometimes changing, sometimes dropping to zero.
      case ($urandom_range(19))
        0:       tilt = 8'd0;
        1, 2, 3: tilt = 8'($urandom_range(255));
        default: ;
      endcase
      s.tilt = tilt;
      pending_samples.push_back(s);
    end
    while (pending_samples.size() != 0 || in_tvalid) @(negedge clk);
    // The sender pauses here until every predicted report is back.
    while (expected_reports.size() != 0) @(negedge clk);
  endtask

  // Main sequence.
  initial begin
    accel_word_t s;
    int unsigned drain;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: a full window at the positive, negative and minus-one extremes.
    for (int i = 0; i < WIN_LEN; i++) begin
      s.x_raw = 8'h1F;
      s.y_raw = 8'h20;
      s.z_raw = 8'hBF;   // bit 7 set, value minus one
      s.tilt = 8'hB8;    // up, tap and shake
      pending_samples.push_back(s);
    end
    // Failure flags on each axis, and tilt changes through every orientation.
    s = '{tilt: 8'h04, z_raw: 8'h00, y_raw: 8'hFF, x_raw: 8'h40};
    pending_samples.push_back(s);
    s = '{tilt: 8'h08, z_raw: 8'h7F, y_raw: 8'h1F, x_raw: 8'hA0};
    pending_samples.push_back(s);
    s = '{tilt: 8'h14, z_raw: 8'h20, y_raw: 8'h60, x_raw: 8'h00};
    pending_samples.push_back(s);
    s = '{tilt: 8'h0C, z_raw: 8'h5F, y_raw: 8'h01, x_raw: 8'hFF};
    pending_samples.push_back(s);
    s = '{tilt: 8'h1C, z_raw: 8'h3F, y_raw: 8'h3E, x_raw: 8'h21};
    pending_samples.push_back(s);
    s = '{tilt: 8'h10, z_raw: 8'h80, y_raw: 8'hC0, x_raw: 8'h1E};
    pending_samples.push_back(s);
    // Tilt falls to zero: this reports, but the next change away from zero does not.
    s = '{tilt: 8'h00, z_raw: 8'h0A, y_raw: 8'h15, x_raw: 8'h2A};
    pending_samples.push_back(s);
    s = '{tilt: 8'h04, z_raw: 8'h35, y_raw: 8'h0B, x_raw: 8'h16};
    pending_samples.push_back(s);
    while (pending_samples.size() != 0 || in_tvalid) @(negedge clk);
    while (expected_reports.size() != 0) @(negedge clk);

    // Random phases with different traffic shapes.
    run_phase(250, 0, 0, 1'b0);
    run_phase(250, 46, 0, 1'b0);
    run_phase(250, 0, 46, 1'b1);
    run_phase(250, 30, 30, 1'b0);

    // Drain with a limit, then allow for the block's pipeline depth.
    drain = 0;
    while (expected_reports.size() != 0 && drain < 5000) begin
      @(negedge clk);
      drain++;
    end
    repeat (10) @(negedge clk);
    if (expected_reports.size() != 0) begin
      mismatches += expected_reports.size();
      $display("Result check failed: %0d predicted reports never arrived",
               expected_reports.size());
    end

    $display("Sent %0d samples (%0d axis bytes flagged as failed), checked %0d reports.",
             samples_taken, failed_axes, reports_seen);
    $display("Input was blocked by back-pressure for %0d cycles; %0d check failures.",
             blocked_cycles, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #4_000_000;
    $display("Timeout waiting for the block to finish");
    $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/amao_pkg.sv
rtl/core/amao_lane.sv
rtl/core/accel_moving_average_orientation.sv
rtl/core/amao_checker.sv
verif/tb.sv
